@@ src/ted_pkg.sv @@
`default_nettype none

package ted_pkg;

  // Encoding class codes
  typedef logic [2:0] enc_class_t;

  localparam enc_class_t CLS_OTHER    = 3'd0;
  localparam enc_class_t CLS_UTF8_BOM = 3'd1;
  localparam enc_class_t CLS_UTF16_LE = 3'd2;
  localparam enc_class_t CLS_UTF16_BE = 3'd3;
  localparam enc_class_t CLS_UTF8     = 3'd4;
  localparam enc_class_t CLS_ASCII    = 3'd5;

  // Byte-order mark bytes
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;

  // UTF-8 lead/continuation boundaries
  localparam logic [7:0] UTF8_CONT_MASK = 8'hC0;
  localparam logic [7:0] UTF8_CONT      = 8'h80;
  localparam logic [7:0] UTF8_LEAD2     = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3     = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4     = 8'hF0;

  // Register geometry
  localparam int unsigned WIN_W = 12;
  localparam logic [WIN_W-1:0] WIN_RESET = 12'd1000;
  localparam logic [WIN_W-1:0] WIN_MIN   = 12'd2;

endpackage

`default_nettype wire

@@ src/text_encoding_detector.sv @@
// A class is out in the cycle after the last byte of a file is accepted.
// Throughput: one byte per cycle; the per-byte UTF-8 check and state update sit
// between the input handshake and the result register, so bytes stream unbroken.
// While a result waits with out_ready low, in_ready is low and input stalls.
// Reset (rst, synchronous): file state cleared, window length back to 1000.
`default_nettype none

module text_encoding_detector
  import ted_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [WIN_W-1:0]  cfg_data,
  // byte input
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  // class output
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             encoding_class
);

  logic [WIN_W-1:0] test_window_len;
  logic [WIN_W-1:0] byte_count, byte_count_next;
  logic [7:0]       first_seen_byte, first_seen_byte_next;
  logic [7:0]       second_seen_byte, second_seen_byte_next;
  logic [1:0]       bytes_pending, bytes_pending_next;
  logic             sequence_bad, sequence_bad_next;
  logic             utf8_invalid, utf8_invalid_next;
  enc_class_t       class_next;

  logic [WIN_W-1:0] limit;
  logic             check_en;
  logic             cont_bad;
  logic             bad_tmp;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  assign limit    = (test_window_len < WIN_MIN) ? WIN_MIN : test_window_len;
  assign check_en = byte_count < test_window_len;
  assign cont_bad = (data_byte & UTF8_CONT_MASK) != UTF8_CONT;

  // Per-byte state update and classification
  always_comb begin
    bad_tmp               = 1'b0;
    first_seen_byte_next  = first_seen_byte;
    second_seen_byte_next = second_seen_byte;
    bytes_pending_next    = bytes_pending;
    sequence_bad_next     = sequence_bad;
    utf8_invalid_next     = utf8_invalid;

    // capture the two mark bytes
    if (byte_count == '0) begin
      first_seen_byte_next = data_byte;
    end else if (byte_count == WIN_W'(1)) begin
      second_seen_byte_next = data_byte;
    end

    // UTF-8 check inside the window, frozen once invalid
    if (check_en && !utf8_invalid) begin
      if (bytes_pending != 2'd0) begin
        bad_tmp            = sequence_bad | cont_bad;
        bytes_pending_next = bytes_pending - 2'd1;
        if (bytes_pending_next == 2'd0) begin
          utf8_invalid_next = bad_tmp;
          sequence_bad_next = 1'b0;
        end else begin
          sequence_bad_next = bad_tmp;
        end
      end else if (data_byte < UTF8_CONT) begin
        // plain ASCII
      end else if (data_byte < UTF8_LEAD2) begin
        utf8_invalid_next = 1'b1;
      end else if (data_byte < UTF8_LEAD3) begin
        bytes_pending_next = 2'd1;
        sequence_bad_next  = 1'b0;
      end else if (data_byte < UTF8_LEAD4) begin
        bytes_pending_next = 2'd2;
        sequence_bad_next  = 1'b0;
      end else begin
        utf8_invalid_next = 1'b1;
      end
    end

    // saturating byte counter
    byte_count_next = (byte_count < limit) ? byte_count + WIN_W'(1) : byte_count;

    // class on the final byte
    if (byte_count == '0) begin
      class_next = CLS_OTHER;
    end else if (first_seen_byte_next == BOM_EF && second_seen_byte_next == BOM_BB) begin
      class_next = CLS_UTF8_BOM;
    end else if (first_seen_byte_next == BOM_FF && second_seen_byte_next == BOM_FE) begin
      class_next = CLS_UTF16_LE;
    end else if (first_seen_byte_next == BOM_FE && second_seen_byte_next == BOM_FF) begin
      class_next = CLS_UTF16_BE;
    end else if (utf8_invalid_next) begin
      class_next = CLS_ASCII;
    end else begin
      class_next = CLS_UTF8;
    end
  end

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      test_window_len <= WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      test_window_len <= cfg_data;
    end
  end

  // File state; cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      first_seen_byte  <= '0;
      second_seen_byte <= '0;
      bytes_pending    <= '0;
      sequence_bad     <= 1'b0;
      utf8_invalid     <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count       <= '0;
        first_seen_byte  <= '0;
        second_seen_byte <= '0;
        bytes_pending    <= '0;
        sequence_bad     <= 1'b0;
        utf8_invalid     <= 1'b0;
      end else begin
        byte_count       <= byte_count_next;
        first_seen_byte  <= first_seen_byte_next;
        second_seen_byte <= second_seen_byte_next;
        bytes_pending    <= bytes_pending_next;
        sequence_bad     <= sequence_bad_next;
        utf8_invalid     <= utf8_invalid_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      encoding_class <= class_next;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/text_encoding_detector_test.sv @@
`timescale 1ns / 1ps

module text_encoding_detector_test;
  import ted_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int BYTES_PER_WINDOW = 125;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [WIN_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       data_byte = 8'h00;
  logic             last_byte = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [2:0]       encoding_class;

  text_encoding_detector uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .encoding_class (encoding_class)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Detector state as predicted on the testbench side
  logic [WIN_W-1:0] win_len;
  logic [WIN_W-1:0] seen_count;
  logic [7:0]       head0, head1;
  logic [1:0]       cont_due;
  logic             cont_broken;
  logic             text_bad;

  enc_class_t  class_q[$];
  logic [7:0]  text_q[$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned classes_checked = 0;
  int unsigned window_writes = 0;
  int unsigned err_count = 0;
  int unsigned stall_cycles = 0;
  enc_class_t  want_cls;

  function automatic void clear_detector();
    seen_count  = '0;
    head0       = 8'h00;
    head1       = 8'h00;
    cont_due    = 2'd0;
    cont_broken = 1'b0;
    text_bad    = 1'b0;
  endfunction

  // Advance the predicted state by one input word; returns 1 when a class is due
  function automatic bit step_detector(input logic [7:0] b, input logic lst,
                                       output enc_class_t cls);
    logic [WIN_W-1:0] sat;
    logic [WIN_W-1:0] pos;
    sat = (win_len < WIN_MIN) ? WIN_MIN : win_len;
    pos = seen_count;
    cls = CLS_OTHER;
    if (pos == 0)
      head0 = b;
    else if (pos == 1)
      head1 = b;
    // UTF-8 check only inside the window, and only until the first failure
    if (pos < win_len && !text_bad) begin
      if (cont_due != 2'd0) begin
        if ((b & UTF8_CONT_MASK) != UTF8_CONT)
          cont_broken = 1'b1;
        cont_due = cont_due - 2'd1;
        if (cont_due == 2'd0) begin
          if (cont_broken)
            text_bad = 1'b1;
          cont_broken = 1'b0;
        end
      end else if (b >= UTF8_LEAD4 || (b >= UTF8_CONT && b < UTF8_LEAD2)) begin
        text_bad = 1'b1;
      end else if (b >= UTF8_LEAD3) begin
        cont_due    = 2'd2;
        cont_broken = 1'b0;
      end else if (b >= UTF8_LEAD2) begin
        cont_due    = 2'd1;
        cont_broken = 1'b0;
      end
    end
    if (seen_count < sat)
      seen_count = seen_count + WIN_W'(1);
    if (!lst)
      return 1'b0;
    if (pos == 0)
      cls = CLS_OTHER;
    else if (head0 == BOM_EF && head1 == BOM_BB)
      cls = CLS_UTF8_BOM;
    else if (head0 == BOM_FF && head1 == BOM_FE)
      cls = CLS_UTF16_LE;
    else if (head0 == BOM_FE && head1 == BOM_FF)
      cls = CLS_UTF16_BE;
    else if (text_bad)
      cls = CLS_ASCII;
    else
      cls = CLS_UTF8;
    clear_detector();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [2:0] got,
                                 input logic [2:0] want);
    $display("[%0t] mismatch: %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (class_q.size() == 0) begin
        report_mismatch("class with nothing expected", encoding_class, 3'd0);
      end else begin
        want_cls = class_q.pop_front();
        if (encoding_class !== want_cls)
          report_mismatch("encoding_class", encoding_class, want_cls);
        classes_checked++;
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] timeout: no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Send one input word, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic lst);
    enc_class_t cls;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (step_detector(b, lst, cls))
      class_q.push_back(cls);
  endtask

  // Send text_q; the final byte is flagged only when the file is closed
  task automatic send_file(input bit close_file);
    int i;
    for (i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], close_file && (i == text_q.size() - 1));
    if (close_file)
      files_sent++;
  endtask

  // Hold input low until every class is back, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (class_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] len);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_len = len;
    window_writes++;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Random file: well-formed UTF-8, broken UTF-8, or noise
  task automatic build_file();
    int kind;
    int nchar;
    int k;
    logic [7:0] bad;
    text_q.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      nchar = $urandom_range(1, 12);
      repeat (nchar) text_q.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(2))
          0: begin
            text_q.push_back(BOM_EF);
            text_q.push_back(BOM_BB);
            if ($urandom_range(1) != 0)
              text_q.push_back(8'hBF);
          end
          1: begin
            text_q.push_back(BOM_FF);
            text_q.push_back(BOM_FE);
          end
          default: begin
            text_q.push_back(BOM_FE);
            text_q.push_back(BOM_FF);
          end
        endcase
      end
      nchar = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      repeat (nchar) begin
        case ($urandom_range(3))
          0, 1: text_q.push_back(8'($urandom_range(8'h7F)));
          2: begin
            text_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
          end
          default: begin
            text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
          end
        endcase
      end
      // corrupt one spot
      if (kind >= 60 && text_q.size() != 0) begin
        k = $urandom_range(text_q.size() - 1);
        case ($urandom_range(2))
          0: text_q.insert(k, 8'($urandom_range(8'h80, 8'hBF)));
          1: text_q.insert(k, 8'($urandom_range(8'hF0, 8'hFF)));
          default: begin
            bad = 8'($urandom_range(255));
            if (bad[7:6] == 2'b10)
              bad[7] = 1'b0;
            text_q[k] = bad;
          end
        endcase
      end
      // sometimes end the file in the middle of a sequence
      if ($urandom_range(7) == 0 && text_q.size() > 1)
        void'(text_q.pop_back());
      if (text_q.size() == 0)
        text_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Byte-order marks, short files, and the basic UTF-8 verdicts at the reset window
  task automatic test_marks_and_sequences();
    text_q = '{8'h41};                                 send_file(1'b1);
    text_q = '{BOM_EF, BOM_BB};                        send_file(1'b1);
    text_q = '{BOM_FF, BOM_FE};                        send_file(1'b1);
    text_q = '{BOM_FE, BOM_FF};                        send_file(1'b1);
    text_q = '{8'h00, 8'h7F};                          send_file(1'b1);
    text_q = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC};     send_file(1'b1);
    // stray continuation, lead too high, bad continuation
    text_q = '{8'h80, 8'h41};                          send_file(1'b1);
    text_q = '{8'hF0, 8'h41};                          send_file(1'b1);
    text_q = '{8'hC3, 8'h41, 8'h41};                   send_file(1'b1);
    // sequence cut by end of file
    text_q = '{8'h41, 8'hE2, 8'h82};                   send_file(1'b1);
  endtask

  // Window limits: cut at window end, deferred verdict, window below two
  task automatic test_window_edges();
    set_window(WIN_MIN);
    text_q = '{8'h41, 8'hE2, 8'h28};                   send_file(1'b1);
    set_window(12'd3);
    text_q = '{8'hE2, 8'h28, 8'h80};                   send_file(1'b1);
    text_q = '{8'h80, 8'hC3};                          send_file(1'b1);
    set_window(12'd0);
    text_q = '{8'h80, 8'h80};                          send_file(1'b1);
    set_window(12'd1);
    text_q = '{8'h41, 8'h80, 8'hFF};                   send_file(1'b1);
    set_window(12'd4095);
    text_q = '{8'hFF, 8'h41};                          send_file(1'b1);
  endtask

  // Window shrinks while a file is open
  task automatic test_window_mid_file();
    set_window(WIN_RESET);
    text_q = '{8'h41, 8'h41};                          send_file(1'b0);
    set_window(WIN_MIN);
    text_q = '{8'h80};                                 send_file(1'b1);
  endtask

  task automatic test_random_traffic();
    int m;
    int w;
    int unsigned target;
    logic [WIN_W-1:0] wins[4];
    for (m = 0; m < 4; m++) begin
      case (m)
        0: set_idle(0, 0);
        1: set_idle(62, 0);
        2: set_idle(0, 62);
        default: set_idle(17, 17);
      endcase
      wins[0] = 12'd4095;
      wins[1] = WIN_MIN;
      wins[2] = 12'($urandom_range(3, 12));
      wins[3] = 12'($urandom_range(2, 4095));
      for (w = 0; w < 4; w++) begin
        set_window(wins[w]);
        target = bytes_sent + BYTES_PER_WINDOW;
        while (bytes_sent < target) begin
          build_file();
          send_file(1'b1);
        end
      end
    end
  endtask

  initial begin
    win_len = WIN_RESET;
    clear_detector();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_marks_and_sequences();
    test_window_edges();
    test_window_mid_file();
    test_random_traffic();

    wait_drained();
    while (class_q.size() != 0)
      report_mismatch("class never produced", 3'd0, class_q.pop_front());

    $display("ran %0d bytes in %0d files, %0d classes checked, %0d window writes",
             bytes_sent, files_sent, classes_checked, window_writes);
    $display("idle modes: none, sender 62%%, receiver 62%%, both 17%%");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", err_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
